// ===== hdl/nns_pkg.sv =====
// Shared types, reset values and the axis step function of the scale addresser.
`default_nettype none
package nns_pkg;

  localparam int unsigned DIM_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] RST_SOURCE_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0] RST_SOURCE_HEIGHT = 12'd400;
  localparam logic [DIM_W-1:0] RST_TARGET_WIDTH  = 12'd1024;
  localparam logic [DIM_W-1:0] RST_TARGET_HEIGHT = 12'd768;

  localparam int unsigned DEF_MAX_TARGET_WIDTH  = 3840;
  localparam int unsigned DEF_MAX_TARGET_HEIGHT = 2160;

  typedef logic [DIM_W-1:0] dim_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 2'd0,
    CFG_SOURCE_HEIGHT = 2'd1,
    CFG_TARGET_WIDTH  = 2'd2,
    CFG_TARGET_HEIGHT = 2'd3
  } cfg_idx_t;

  // Quotient and remainder of one axis
  typedef struct packed {
    dim_t quo;
    dim_t rem;
  } div_res_t;

  // Source index and Bresenham remainder of one axis
  typedef struct packed {
    dim_t idx;
    dim_t acc;
  } axis_t;

  typedef struct packed {
    dim_t src_col;
    dim_t src_row;
    dim_t dst_col;
    dim_t dst_row;
    logic repeat_row;
    logic row_end;
    logic frame_end;
  } pix_t;

  // One step: idx += q, acc += r, one carry correction (acc cleared if still >= dst), clamp to src - 1.
  function automatic axis_t axis_advance(input axis_t cur, input div_res_t st,
                                         input dim_t dst, input dim_t src);
    logic [DIM_W:0] i;
    logic [DIM_W:0] a;
    axis_t          res;
    i = {1'b0, cur.idx} + {1'b0, st.quo};
    a = {1'b0, cur.acc} + {1'b0, st.rem};
    if (a >= {1'b0, dst}) begin
      a = a - {1'b0, dst};
      i = i + 1'b1;
    end
    if (a >= {1'b0, dst}) begin
      a = '0;
    end
    if (i >= {1'b0, src}) begin
      i = {1'b0, src} - 1'b1;
    end
    res.idx = i[DIM_W-1:0];
    res.acc = a[DIM_W-1:0];
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/nearest_neighbour_scale_addresser.sv =====
// Nearest-neighbour scaling address generator: top level.
// Each transfer on the in_ channel produces one destination pixel in raster
// order on the out_ channel: source column/row to read, destination column/
// row, repeat_row, row_end and frame_end. in_restart = 1 jumps back to
// destination pixel zero and emits it.
// Each input transfer is registered into the output register, or into the
// skid register behind it while a result is stalled. One pixel per clock is
// sustained while out_ready is high and the divider is idle. Once the skid
// is full, in_ready drops until the receiver takes a result.
// Sizes are written through cfg_we/cfg_index/cfg_wdata while no pixels are in
// flight. Each write returns the walk to pixel zero and reruns the per-axis
// quotient/remainder divider: in_ready is low while the divider is launched and
// runs its 12 divide steps, both axes in parallel. Reset loads the default
// sizes and runs the same computation before the first input.
// Zero sizes count as one; target sizes saturate at MAX_TARGET_WIDTH/HEIGHT.
`default_nettype none
module nearest_neighbour_scale_addresser #(
  parameter int unsigned MAX_TARGET_WIDTH  = nns_pkg::DEF_MAX_TARGET_WIDTH,
  parameter int unsigned MAX_TARGET_HEIGHT = nns_pkg::DEF_MAX_TARGET_HEIGHT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [nns_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire nns_pkg::dim_t                    cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_restart,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output nns_pkg::dim_t                         out_src_col,
  output nns_pkg::dim_t                         out_src_row,
  output nns_pkg::dim_t                         out_dst_col,
  output nns_pkg::dim_t                         out_dst_row,
  output logic                                  out_repeat_row,
  output logic                                  out_row_end,
  output logic                                  out_frame_end
);
  import nns_pkg::*;

  localparam dim_t MAX_TW = DIM_W'(MAX_TARGET_WIDTH);
  localparam dim_t MAX_TH = DIM_W'(MAX_TARGET_HEIGHT);

  // configuration
  dim_t src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  dim_t sw, sh, tw, th;
  logic div_go_r;
  logic col_busy, row_busy, busy;
  div_res_t col_step, row_step;

  // walk state
  dim_t  col_cnt_r, col_cnt_nxt;
  dim_t  row_cnt_r, row_cnt_nxt;
  axis_t col_ax_r, col_ax_nxt;
  axis_t row_ax_r, row_ax_nxt;
  dim_t  prior_src_r, prior_src_nxt;

  // walk view after an optional restart
  dim_t  b_col_cnt, b_row_cnt, b_prior;
  axis_t b_col_ax, b_row_ax;
  logic  row_end, frame_end, repeat_row;
  pix_t  pix;

  // output register and skid
  pix_t out_r, skid_r;
  logic out_vld_r, skid_vld_r;
  logic in_xfer, out_xfer;

  assign sw = (src_w_r == '0) ? DIM_W'(1) : src_w_r;
  assign sh = (src_h_r == '0) ? DIM_W'(1) : src_h_r;
  assign tw = (tgt_w_r == '0) ? DIM_W'(1) : ((tgt_w_r > MAX_TW) ? MAX_TW : tgt_w_r);
  assign th = (tgt_h_r == '0) ? DIM_W'(1) : ((tgt_h_r > MAX_TH) ? MAX_TH : tgt_h_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= RST_SOURCE_WIDTH;
      src_h_r  <= RST_SOURCE_HEIGHT;
      tgt_w_r  <= RST_TARGET_WIDTH;
      tgt_h_r  <= RST_TARGET_HEIGHT;
      div_go_r <= 1'b1;
    end else begin
      div_go_r <= cfg_we;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SOURCE_WIDTH:  src_w_r <= cfg_wdata;
          CFG_SOURCE_HEIGHT: src_h_r <= cfg_wdata;
          CFG_TARGET_WIDTH:  tgt_w_r <= cfg_wdata;
          CFG_TARGET_HEIGHT: tgt_h_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  nns_div u_col_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (sw),
    .divisor  (tw),
    .busy     (col_busy),
    .result   (col_step)
  );

  nns_div u_row_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (sh),
    .divisor  (th),
    .busy     (row_busy),
    .result   (row_step)
  );

  assign busy     = div_go_r || col_busy || row_busy;
  assign in_ready = !busy && !skid_vld_r;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_vld_r && out_ready;

  always_comb begin
    if (in_restart) begin
      b_col_cnt = '0;
      b_row_cnt = '0;
      b_col_ax  = '0;
      b_row_ax  = '0;
      b_prior   = '0;
    end else begin
      b_col_cnt = col_cnt_r;
      b_row_cnt = row_cnt_r;
      b_col_ax  = col_ax_r;
      b_row_ax  = row_ax_r;
      b_prior   = prior_src_r;
    end

    row_end    = ({1'b0, b_col_cnt} + 1'b1) >= {1'b0, tw};
    frame_end  = row_end && (({1'b0, b_row_cnt} + 1'b1) >= {1'b0, th});
    repeat_row = (b_row_cnt != '0) && (b_row_ax.idx == b_prior);

    pix.src_col    = b_col_ax.idx;
    pix.src_row    = b_row_ax.idx;
    pix.dst_col    = b_col_cnt;
    pix.dst_row    = b_row_cnt;
    pix.repeat_row = repeat_row;
    pix.row_end    = row_end;
    pix.frame_end  = frame_end;

    col_cnt_nxt   = b_col_cnt;
    row_cnt_nxt   = b_row_cnt;
    col_ax_nxt    = b_col_ax;
    row_ax_nxt    = b_row_ax;
    prior_src_nxt = b_prior;
    if (frame_end) begin
      col_cnt_nxt   = '0;
      row_cnt_nxt   = '0;
      col_ax_nxt    = '0;
      row_ax_nxt    = '0;
      prior_src_nxt = '0;
    end else if (row_end) begin
      col_cnt_nxt   = '0;
      col_ax_nxt    = '0;
      prior_src_nxt = b_row_ax.idx;
      row_cnt_nxt   = b_row_cnt + 1'b1;
      row_ax_nxt    = axis_advance(b_row_ax, row_step, th, sh);
    end else begin
      col_cnt_nxt   = b_col_cnt + 1'b1;
      col_ax_nxt    = axis_advance(b_col_ax, col_step, tw, sw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      col_ax_r    <= '0;
      row_ax_r    <= '0;
      prior_src_r <= '0;
    end else if (cfg_we) begin
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      col_ax_r    <= '0;
      row_ax_r    <= '0;
      prior_src_r <= '0;
    end else if (in_xfer) begin
      col_cnt_r   <= col_cnt_nxt;
      row_cnt_r   <= row_cnt_nxt;
      col_ax_r    <= col_ax_nxt;
      row_ax_r    <= row_ax_nxt;
      prior_src_r <= prior_src_nxt;
    end
  end

  // Output register drains first; skid holds one pixel while out is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_xfer) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r  <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_xfer) begin
      if (skid_vld_r) begin
        out_r <= skid_r;
      end else if (in_xfer) begin
        out_r <= pix;
      end
    end else if (in_xfer) begin
      skid_r <= pix;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_src_col    = out_r.src_col;
  assign out_src_row    = out_r.src_row;
  assign out_dst_col    = out_r.dst_col;
  assign out_dst_row    = out_r.dst_row;
  assign out_repeat_row = out_r.repeat_row;
  assign out_row_end    = out_r.row_end;
  assign out_frame_end  = out_r.frame_end;

endmodule
`default_nettype wire

// ===== hdl/nns_div.sv =====
// Restoring divider, one quotient bit per cycle, for the per-axis step sizes.
`default_nettype none
module nns_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire nns_pkg::dim_t   dividend,
  input  wire nns_pkg::dim_t   divisor,
  output logic                 busy,
  output nns_pkg::div_res_t    result
);
  import nns_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIM_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  dim_t             dvd_r, dvd_nxt;   // dividend bits out, quotient bits in
  dim_t             rem_r, rem_nxt;
  dim_t             dsr_r, dsr_nxt;
  logic [DIM_W:0]   rem_sh;
  logic             q_bit;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[DIM_W-1]};
    q_bit   = rem_sh >= {1'b0, dsr_r};
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    if (start) begin
      cnt_nxt = CNT_W'(DIM_W);
      dvd_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      dvd_nxt = {dvd_r[DIM_W-2:0], q_bit};
      if (q_bit) begin
        rem_nxt = DIM_W'(rem_sh - {1'b0, dsr_r});
      end else begin
        rem_nxt = rem_sh[DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy       = cnt_r != '0;
  assign result.quo = dvd_r;
  assign result.rem = rem_r;

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the nearest-neighbour scale addresser: predictor, scoreboard and stimulus.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nns_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_TICKS = 600;
  localparam int unsigned DIM_MASK = 32'hFFF;

  // Tracks the raster walk and holds the pixels still owed by the block
  class scale_walk_model;
    dim_t reg_src_w, reg_src_h, reg_dst_w, reg_dst_h;
    int unsigned col_pos, row_pos, col_src, row_src, col_acc, row_acc, last_row_src;
    int unsigned col_quo, col_rem, row_quo, row_rem;
    pix_t pending_pixels[$];
    int unsigned errors;

    function new();
      reg_src_w = RST_SOURCE_WIDTH;
      reg_src_h = RST_SOURCE_HEIGHT;
      reg_dst_w = RST_TARGET_WIDTH;
      reg_dst_h = RST_TARGET_HEIGHT;
      errors = 0;
      split_ratios();
      go_origin();
    endfunction

    function int unsigned src_span(dim_t v);
      return (v == 0) ? 1 : int'(v);
    endfunction

    function int unsigned dst_span(dim_t v, int unsigned cap);
      if (v == 0) return 1;
      return (v > cap) ? cap : int'(v);
    endfunction

    function void split_ratios();
      int unsigned sw, sh, tw, th;
      sw = src_span(reg_src_w);
      sh = src_span(reg_src_h);
      tw = dst_span(reg_dst_w, DEF_MAX_TARGET_WIDTH);
      th = dst_span(reg_dst_h, DEF_MAX_TARGET_HEIGHT);
      col_quo = (sw / tw) & DIM_MASK;
      col_rem = (sw % tw) & DIM_MASK;
      row_quo = (sh / th) & DIM_MASK;
      row_rem = (sh % th) & DIM_MASK;
    endfunction

    function void go_origin();
      col_pos = 0;
      row_pos = 0;
      col_src = 0;
      row_src = 0;
      col_acc = 0;
      row_acc = 0;
      last_row_src = 0;
    endfunction

    function void load_reg(cfg_idx_t idx, dim_t val);
      case (idx)
        CFG_SOURCE_WIDTH:  reg_src_w = val;
        CFG_SOURCE_HEIGHT: reg_src_h = val;
        CFG_TARGET_WIDTH:  reg_dst_w = val;
        CFG_TARGET_HEIGHT: reg_dst_h = val;
        default: ;
      endcase
      split_ratios();
      go_origin();
    endfunction

    // Bresenham step with a single carry fix-up and clamp to the last source pixel
    function void step_axis(inout int unsigned idx, inout int unsigned acc,
                            input int unsigned q, input int unsigned r,
                            input int unsigned dst, input int unsigned src);
      int unsigned i, a;
      i = idx + q;
      a = acc + r;
      if (a >= dst) begin
        a = a - dst;
        i = i + 1;
      end
      if (a >= dst) a = 0;
      if (i >= src) i = src - 1;
      idx = i & DIM_MASK;
      acc = a & DIM_MASK;
    endfunction

    function void note_tick(bit restart);
      int unsigned tw, th, sw, sh;
      bit last_col, last_pix, rep;
      pix_t p;
      tw = dst_span(reg_dst_w, DEF_MAX_TARGET_WIDTH);
      th = dst_span(reg_dst_h, DEF_MAX_TARGET_HEIGHT);
      sw = src_span(reg_src_w);
      sh = src_span(reg_src_h);
      if (restart) go_origin();
      last_col = (col_pos + 1 >= tw);
      last_pix = last_col && (row_pos + 1 >= th);
      rep = (row_pos != 0) && (row_src == last_row_src);
      p.src_col = dim_t'(col_src);
      p.src_row = dim_t'(row_src);
      p.dst_col = dim_t'(col_pos);
      p.dst_row = dim_t'(row_pos);
      p.repeat_row = rep;
      p.row_end = last_col;
      p.frame_end = last_pix;
      pending_pixels.push_back(p);
      if (last_pix) begin
        go_origin();
      end else if (last_col) begin
        col_pos = 0;
        col_src = 0;
        col_acc = 0;
        last_row_src = row_src;
        row_pos = (row_pos + 1) & DIM_MASK;
        step_axis(row_src, row_acc, row_quo, row_rem, th, sh);
      end else begin
        col_pos = (col_pos + 1) & DIM_MASK;
        step_axis(col_src, col_acc, col_quo, col_rem, tw, sw);
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_pixel(pix_t got);
      pix_t want;
      if (pending_pixels.size() == 0) begin
        $error("pixel transfer with nothing expected: dst_col %0d dst_row %0d",
               got.dst_col, got.dst_row);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("src_col", want.src_col, got.src_col);
      compare_field("src_row", want.src_row, got.src_row);
      compare_field("dst_col", want.dst_col, got.dst_col);
      compare_field("dst_row", want.dst_row, got.dst_row);
      compare_field("repeat_row", want.repeat_row, got.repeat_row);
      compare_field("row_end", want.row_end, got.row_end);
      compare_field("frame_end", want.frame_end, got.frame_end);
    endfunction

    function int unsigned outstanding();
      return pending_pixels.size();
    endfunction
  endclass

  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_TRICKLE} rx_pattern_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SOURCE_WIDTH;
  dim_t cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  dim_t out_src_col, out_src_row, out_dst_col, out_dst_row;
  logic out_repeat_row, out_row_end, out_frame_end;

  scale_walk_model walk = new();
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned rx_cycle = 0;
  rx_pattern_t rx_mode = RX_OPEN;

  nearest_neighbour_scale_addresser uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_src_col    (out_src_col),
    .out_src_row    (out_src_row),
    .out_dst_col    (out_dst_col),
    .out_dst_row    (out_dst_row),
    .out_repeat_row (out_repeat_row),
    .out_row_end    (out_row_end),
    .out_frame_end  (out_frame_end)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: check every transfer, stall on a pattern that changes now and then
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      walk.match_pixel(pix_t'({out_src_col, out_src_row, out_dst_col, out_dst_row,
                               out_repeat_row, out_row_end, out_frame_end}));
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = rx_pattern_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:         out_ready <= 1'b1;
      RX_COIN:         out_ready <= 1'($urandom_range(0, 1));
      RX_EVERY_FOURTH: out_ready <= (rx_cycle % 4 == 0);
      default:         out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // One input transfer, then maybe a gap once the current burst runs out
  task automatic send_tick(input bit restart);
    int unsigned gap;
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    walk.note_tick(restart);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off the sender until every owed pixel has come back
  task automatic settle();
    if (walk.outstanding() != 0) begin
      in_valid <= 1'b0;
      while (walk.outstanding() != 0) @(posedge clk);
    end
  endtask

  // Each write reruns the divider; in_ready stays low until it is done
  task automatic write_size(input cfg_idx_t idx, input dim_t val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    walk.load_reg(idx, val);
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int unsigned random_sent;
    int unsigned n;
    int unsigned start;
    int unsigned mask;
    int unsigned r;
    cfg_idx_t idx;
    dim_t val;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (!in_ready);

    // reset sizes, with a restart in the middle
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);

    // zero sizes count as one: every pixel ends the frame
    settle();
    write_size(CFG_SOURCE_WIDTH, 12'd0);
    write_size(CFG_SOURCE_HEIGHT, 12'd0);
    write_size(CFG_TARGET_WIDTH, 12'd0);
    write_size(CFG_TARGET_HEIGHT, 12'd0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);

    // largest sizes; targets saturate at the maximum
    settle();
    write_size(CFG_SOURCE_WIDTH, 12'd4095);
    write_size(CFG_SOURCE_HEIGHT, 12'd4095);
    write_size(CFG_TARGET_WIDTH, 12'd4095);
    write_size(CFG_TARGET_HEIGHT, 12'd4095);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);

    // one-pixel rows walk the saturated height
    settle();
    write_size(CFG_TARGET_WIDTH, 12'd1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);

    // small upscale: repeated rows, full frame after a restart, then the wrap
    settle();
    write_size(CFG_SOURCE_WIDTH, 12'd3);
    write_size(CFG_SOURCE_HEIGHT, 12'd2);
    write_size(CFG_TARGET_WIDTH, 12'd4);
    write_size(CFG_TARGET_HEIGHT, 12'd3);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    repeat (12) send_tick(1'b0);

    random_sent = 0;
    while (random_sent < RANDOM_TICKS) begin
      settle();
      start = $urandom_range(0, 3);
      mask = $urandom_range(1, 15);
      for (int k = 0; k < 4; k++) begin
        if (mask[k]) begin
          idx = cfg_idx_t'((start + k) % 4);
          r = $urandom_range(0, 9);
          if (idx == CFG_SOURCE_WIDTH || idx == CFG_SOURCE_HEIGHT) begin
            case (r)
              0:       val = 12'd0;
              1:       val = 12'd4095;
              2:       val = dim_t'($urandom_range(0, 4095));
              default: val = dim_t'($urandom_range(1, 12));
            endcase
          end else begin
            case (r)
              0: begin
                case ($urandom_range(0, 5))
                  0:       val = 12'd0;
                  1:       val = 12'd1;
                  2:       val = 12'd3839;
                  3:       val = 12'd3840;
                  4:       val = 12'd3841;
                  default: val = 12'd4095;
                endcase
              end
              1:       val = dim_t'($urandom_range(0, 4095));
              default: val = dim_t'($urandom_range(1, 10));
            endcase
          end
          write_size(idx, val);
        end
      end
      n = $urandom_range(16, 80);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 49) == 0) settle();
        send_tick($urandom_range(0, 24) == 0);
        random_sent++;
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (walk.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
